FILE: rtl/core/ostm_pkg.sv
// Shared constants, codes and types for the one-shot sample trigger mixer.
// No dependencies; every other file of the block refers to it by scoped names.
package ostm_pkg;

	// Storage sizes
	localparam int WAVE_DEPTH  = 4096;
	localparam int VOICE_COUNT = 16;
	localparam int WAVE_AW     = $clog2(WAVE_DEPTH);
	localparam int EFF_W       = $clog2(WAVE_DEPTH + 1);
	localparam int VOICE_W     = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int CNT_W       = $clog2(VOICE_COUNT + 1);

	// Field widths
	localparam int IDX_W    = 12;
	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 16;
	localparam int LEN_W    = 13;
	localparam int GAP_W    = 8;
	localparam int CFG_W    = 16;
	localparam int CFG_AW   = 2;
	localparam int ACT_W    = 5;
	localparam int IN_W     = 48;
	localparam int OUT_W    = 24;

	// Datapath widths: wave x gain product, voice sum, scaling operand, scaled product
	localparam int PROD_W = 32;
	localparam int ACC_W  = PROD_W + CNT_W;
	localparam int M_W    = ACC_W + 2;
	localparam int P_W    = M_W + GAIN_W + 1;

	// Scaling constants
	localparam int GAIN_SHIFT  = 15;
	localparam int FINAL_SHIFT = 27;
	localparam logic [GAIN_W-1:0] FULL_SCALE = 16'd32767;
	localparam logic signed [P_W-1:0] GAIN_MASK  = P_W'((64'd1 << GAIN_SHIFT) - 64'd1);
	localparam logic signed [P_W-1:0] FINAL_MASK = P_W'((64'd1 << FINAL_SHIFT) - 64'd1);
	localparam logic signed [M_W-1:0] SAT_MAX = M_W'(32767);
	localparam logic signed [M_W-1:0] SAT_MIN = -M_W'(32768);
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7FFF;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;
	localparam logic [ACT_W-1:0] ACT_MAX = 5'd31;

	// Register reset values
	localparam logic [LEN_W-1:0]  RST_SAMPLE_LENGTH = 13'd0;
	localparam logic [GAP_W-1:0]  RST_MIN_GAP       = 8'd2;
	localparam logic [GAIN_W-1:0] RST_DENSITY_GAIN  = 16'd32768;
	localparam logic [GAIN_W-1:0] RST_OUTPUT_GAIN   = 16'd32113;
	localparam logic [GAP_W-1:0]  TICKS_MAX         = 8'd255;

	// Register indexes
	localparam logic [CFG_AW-1:0] REG_SAMPLE_LENGTH = 2'd0;
	localparam logic [CFG_AW-1:0] REG_MIN_GAP       = 2'd1;
	localparam logic [CFG_AW-1:0] REG_DENSITY_GAIN  = 2'd2;
	localparam logic [CFG_AW-1:0] REG_OUTPUT_GAIN   = 2'd3;

	// Command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Hit status codes
	localparam logic [1:0] HS_NONE    = 2'd0;
	localparam logic [1:0] HS_ACCEPT  = 2'd1;
	localparam logic [1:0] HS_CLOSE   = 2'd2;
	localparam logic [1:0] HS_NOVOICE = 2'd3;

	// Scaling steps
	localparam logic [1:0] STEP_DENSITY = 2'd0;
	localparam logic [1:0] STEP_OUTPUT  = 2'd1;
	localparam logic [1:0] STEP_FULL    = 2'd2;

	typedef enum logic [1:0] {
		SC_IDLE,
		SC_MUL,
		SC_SHIFT,
		SC_DONE
	} scale_state_t;

	// New hit handed to the voice engine at tick start
	typedef struct packed {
		logic               hit;
		logic [VOICE_W-1:0] voice;
		logic [GAIN_W-1:0]  gain;
	} hit_req_t;

	// Finished sample from the scaler
	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                clipped;
	} mix_res_t;

endpackage

FILE: rtl/core/one_shot_sample_trigger_mixer.sv
// Top level of the one-shot sample trigger mixer: stream ports, configuration
// registers, hit gap check and output register. Depends on ostm_pkg,
// ostm_voice_engine and ostm_scaler.
// Usage:
// - Input stream (s_*): s_tuser selects the request kind. A load request writes
//   one waveform word and returns nothing. A tick request returns one sample on
//   the output stream and may start a hit on the lowest free voice.
// - Output stream (m_*): one sample per tick, in tick order.
// - Configuration port: cfg_we writes cfg_data into register cfg_index in the
//   same cycle; write only while no tick is in flight.
// - Sequence: after a tick is accepted the sweep visits one voice per cycle
//   through the voice memory and the single wave x gain multiplier, then three
//   multiply/shift steps on the shared scaling multiplier follow before m_tvalid
//   rises.
// - Throughput: a new tick is taken only once the last sample has gone to the
//   output register; loads are taken one per cycle while no tick is in flight.
// - A stalled output holds its sample in the output register; the next tick is
//   still taken and finishes, then waits in the scaler until the register frees.
// - Reset clears the voices, sets the gap counter to its maximum and the registers
//   to their reset values at once, with no clearing pass; waveform words are undefined until loaded.
module one_shot_sample_trigger_mixer (
	input  logic                          clk,
	input  logic                          arst_n,
	// s_tdata: wave_index[11:0], wave_value[27:12], trigger[28], hit_gain[44:29]
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ostm_pkg::IN_W-1:0]     s_tdata,
	// s_tuser: cmd[0]
	input  logic                          s_tuser,
	// m_tdata: sample_out[15:0], clipped[16], hit_status[18:17], active_voices[23:19]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ostm_pkg::OUT_W-1:0]    m_tdata,
	input  logic                          cfg_we,
	input  logic [ostm_pkg::CFG_AW-1:0]   cfg_index,
	input  logic [ostm_pkg::CFG_W-1:0]    cfg_data
);

	logic [ostm_pkg::IDX_W-1:0]    wave_index;
	logic [ostm_pkg::SAMPLE_W-1:0] wave_value;
	logic                          trigger;
	logic [ostm_pkg::GAIN_W-1:0]   hit_gain;

	logic [ostm_pkg::LEN_W-1:0]  sample_length_q;
	logic [ostm_pkg::GAP_W-1:0]  min_gap_q;
	logic [ostm_pkg::GAIN_W-1:0] density_gain_q;
	logic [ostm_pkg::GAIN_W-1:0] output_gain_q;

	logic [ostm_pkg::GAP_W-1:0] ticks_q, ticks_inc;
	logic                       busy_q;
	logic [1:0]                 status_q, hit_status;
	logic                       m_tvalid_q;
	logic [ostm_pkg::OUT_W-1:0] m_tdata_q;

	logic                           load_acc, tick_acc, too_close, wave_we, take;
	logic [ostm_pkg::EFF_W-1:0]     len_eff;
	logic                           free_found, eng_done, sc_ready;
	logic [ostm_pkg::VOICE_W-1:0]   free_voice;
	logic signed [ostm_pkg::ACC_W-1:0] eng_acc;
	logic [ostm_pkg::CNT_W-1:0]     eng_count;
	logic [ostm_pkg::ACT_W-1:0]     act_sat;
	ostm_pkg::hit_req_t             hit;
	ostm_pkg::mix_res_t             sc_res;

	// Unpack the request
	assign wave_index = s_tdata[11:0];
	assign wave_value = s_tdata[27:12];
	assign trigger    = s_tdata[28];
	assign hit_gain   = s_tdata[44:29];

	assign s_tready = !busy_q;
	assign load_acc = s_tvalid && s_tready && (s_tuser == ostm_pkg::CMD_LOAD);
	assign tick_acc = s_tvalid && s_tready && (s_tuser == ostm_pkg::CMD_TICK);
	assign wave_we  = load_acc && (32'(wave_index) < ostm_pkg::WAVE_DEPTH);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_length_q <= ostm_pkg::RST_SAMPLE_LENGTH;
			min_gap_q       <= ostm_pkg::RST_MIN_GAP;
			density_gain_q  <= ostm_pkg::RST_DENSITY_GAIN;
			output_gain_q   <= ostm_pkg::RST_OUTPUT_GAIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ostm_pkg::REG_SAMPLE_LENGTH: sample_length_q <= cfg_data[ostm_pkg::LEN_W-1:0];
				ostm_pkg::REG_MIN_GAP:       min_gap_q       <= cfg_data[ostm_pkg::GAP_W-1:0];
				ostm_pkg::REG_DENSITY_GAIN:  density_gain_q  <= cfg_data;
				ostm_pkg::REG_OUTPUT_GAIN:   output_gain_q   <= cfg_data;
				default:                     min_gap_q       <= min_gap_q;
			endcase
		end
	end

	// Clamp the waveform length to the store depth
	always_comb begin
		if (32'(sample_length_q) > ostm_pkg::WAVE_DEPTH) begin
			len_eff = ostm_pkg::EFF_W'(ostm_pkg::WAVE_DEPTH);
		end else begin
			len_eff = ostm_pkg::EFF_W'(sample_length_q);
		end
	end

	// Gap check and voice grant
	always_comb begin
		ticks_inc = (ticks_q == ostm_pkg::TICKS_MAX) ? ticks_q : ticks_q + 1'b1;
		too_close = ticks_inc < min_gap_q;
		priority if (!trigger) begin
			hit_status = ostm_pkg::HS_NONE;
		end else if (too_close) begin
			hit_status = ostm_pkg::HS_CLOSE;
		end else if (!free_found) begin
			hit_status = ostm_pkg::HS_NOVOICE;
		end else begin
			hit_status = ostm_pkg::HS_ACCEPT;
		end
		hit.hit   = tick_acc && (hit_status == ostm_pkg::HS_ACCEPT);
		hit.voice = free_voice;
		hit.gain  = hit_gain;
	end

	// Track ticks, busy flag and status of the tick in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q  <= ostm_pkg::TICKS_MAX;
			busy_q   <= 1'b0;
			status_q <= ostm_pkg::HS_NONE;
		end else begin
			if (tick_acc) begin
				ticks_q  <= hit.hit ? '0 : ticks_inc;
				status_q <= hit_status;
				busy_q   <= 1'b1;
			end else if (take) begin
				busy_q <= 1'b0;
			end
		end
	end

	ostm_voice_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.wave_we    (wave_we),
		.wave_addr  (ostm_pkg::WAVE_AW'(wave_index)),
		.wave_wdata (wave_value),
		.start      (tick_acc),
		.hit        (hit),
		.len_eff    (len_eff),
		.free_found (free_found),
		.free_voice (free_voice),
		.done       (eng_done),
		.acc        (eng_acc),
		.count      (eng_count)
	);

	ostm_scaler u_scaler (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (eng_done),
		.acc_in (eng_acc),
		.dgain  (density_gain_q),
		.ogain  (output_gain_q),
		.take   (take),
		.ready  (sc_ready),
		.result (sc_res)
	);

	// Hand the finished sample to the output register when it is free
	assign take = sc_ready && (!m_tvalid_q || m_tready);

	always_comb begin
		if (32'(eng_count) > 32'(ostm_pkg::ACT_MAX)) begin
			act_sat = ostm_pkg::ACT_MAX;
		end else begin
			act_sat = ostm_pkg::ACT_W'(eng_count);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			m_tdata_q <= {act_sat, status_q, sc_res.clipped, sc_res.sample};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	a_take_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> busy_q)
		else $error("sample handed over with no tick in flight");
	a_tick_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> busy_q)
		else $error("tick accepted but block not busy");
	a_hit_resets_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_acc && (hit_status == ostm_pkg::HS_ACCEPT)) |=> (ticks_q == '0))
		else $error("accepted hit did not restart gap count");
`endif

endmodule

FILE: rtl/core/ostm_voice_engine.sv
// Voice engine: waveform memory, voice state memory and the per-tick voice sweep
// with its multiply-accumulate. Depends on ostm_pkg.
module ostm_voice_engine (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   wave_we,
	input  logic [ostm_pkg::WAVE_AW-1:0]           wave_addr,
	input  logic signed [ostm_pkg::SAMPLE_W-1:0]   wave_wdata,
	input  logic                                   start,
	input  ostm_pkg::hit_req_t                     hit,
	input  logic [ostm_pkg::EFF_W-1:0]             len_eff,
	output logic                                   free_found,
	output logic [ostm_pkg::VOICE_W-1:0]           free_voice,
	output logic                                   done,
	output logic signed [ostm_pkg::ACC_W-1:0]      acc,
	output logic [ostm_pkg::CNT_W-1:0]             count
);

	localparam int VE_W = ostm_pkg::WAVE_AW + ostm_pkg::GAIN_W;
	localparam logic [ostm_pkg::VOICE_W-1:0] LAST_VOICE =
		ostm_pkg::VOICE_W'(ostm_pkg::VOICE_COUNT - 1);

	logic signed [ostm_pkg::SAMPLE_W-1:0] wmem [ostm_pkg::WAVE_DEPTH];
	logic [VE_W-1:0]                      vmem [ostm_pkg::VOICE_COUNT];
	logic [ostm_pkg::VOICE_COUNT-1:0]     active_q;

	logic                          sweep_q;
	logic [ostm_pkg::VOICE_W-1:0]  rd_idx_q;

	logic                          valid_s1, last_s1;
	logic [ostm_pkg::VOICE_W-1:0]  idx_s1;
	logic [VE_W-1:0]               vrd_s1;

	logic                          valid_s2, last_s2, live_s2;
	logic [ostm_pkg::GAIN_W-1:0]   gain_s2;
	logic signed [ostm_pkg::SAMPLE_W-1:0] wrd_s2;

	logic                          valid_s3, last_s3;
	logic signed [ostm_pkg::PROD_W-1:0] prod_s3;

	logic signed [ostm_pkg::ACC_W-1:0] acc_q;
	logic [ostm_pkg::CNT_W-1:0]        count_q;
	logic                              done_q;

	logic [ostm_pkg::WAVE_AW-1:0] pos_s1;
	logic [ostm_pkg::GAIN_W-1:0]  gain_s1;
	logic                         act_s1, live_s1, end_s1;
	logic [ostm_pkg::EFF_W-1:0]   pos_inc_s1;
	logic signed [ostm_pkg::PROD_W:0] mult_s2;

	// Find the lowest free voice
	always_comb begin
		free_found = 1'b0;
		free_voice = '0;
		for (int v = ostm_pkg::VOICE_COUNT - 1; v >= 0; v--) begin
			if (!active_q[v]) begin
				free_found = 1'b1;
				free_voice = ostm_pkg::VOICE_W'(v);
			end
		end
	end

	// Walk the voice indexes once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q  <= 1'b0;
			rd_idx_q <= '0;
		end else if (start) begin
			sweep_q  <= 1'b1;
			rd_idx_q <= '0;
		end else if (sweep_q) begin
			if (rd_idx_q == LAST_VOICE) begin
				sweep_q <= 1'b0;
			end else begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	// Decode the voice entry read back in stage 1
	always_comb begin
		pos_s1     = vrd_s1[VE_W-1:ostm_pkg::GAIN_W];
		gain_s1    = vrd_s1[ostm_pkg::GAIN_W-1:0];
		act_s1     = active_q[idx_s1];
		live_s1    = act_s1 && (ostm_pkg::EFF_W'(pos_s1) < len_eff);
		pos_inc_s1 = ostm_pkg::EFF_W'(pos_s1) + 1'b1;
		end_s1     = pos_inc_s1 >= len_eff;
	end

	// Voice state memory: read during the sweep, write a new hit or the advanced position
	always_ff @(posedge clk) begin
		if (sweep_q) begin
			vrd_s1 <= vmem[rd_idx_q];
		end
		if (start && hit.hit) begin
			vmem[hit.voice] <= {{ostm_pkg::WAVE_AW{1'b0}}, hit.gain};
		end else if (valid_s1) begin
			vmem[idx_s1] <= {ostm_pkg::WAVE_AW'(pos_inc_s1), gain_s1};
		end
	end

	// Waveform memory: load writes, sweep reads
	always_ff @(posedge clk) begin
		if (wave_we) begin
			wmem[wave_addr] <= wave_wdata;
		end
		if (valid_s1) begin
			wrd_s2 <= wmem[pos_s1];
		end
	end

	// Set a voice on a hit, drop it when it runs past the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (start && hit.hit) begin
			active_q[hit.voice] <= 1'b1;
		end else if (valid_s1 && act_s1 && (!live_s1 || end_s1)) begin
			active_q[idx_s1] <= 1'b0;
		end
	end

	// Advance pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			idx_s1   <= '0;
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
			live_s2  <= 1'b0;
			valid_s3 <= 1'b0;
			last_s3  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= sweep_q;
			last_s1  <= sweep_q && (rd_idx_q == LAST_VOICE);
			idx_s1   <= rd_idx_q;
			valid_s2 <= valid_s1;
			last_s2  <= valid_s1 && last_s1;
			live_s2  <= valid_s1 && live_s1;
			valid_s3 <= valid_s2;
			last_s3  <= valid_s2 && last_s2;
			done_q   <= valid_s3 && last_s3;
		end
	end

	always_ff @(posedge clk) begin
		gain_s2 <= gain_s1;
	end

	// Multiply wave by voice gain
	assign mult_s2 = wrd_s2 * $signed({1'b0, gain_s2});

	always_ff @(posedge clk) begin
		prod_s3 <= live_s2 ? mult_s2[ostm_pkg::PROD_W-1:0] : '0;
	end

	// Accumulate products and count sounding voices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			count_q <= '0;
		end else if (start) begin
			acc_q   <= '0;
			count_q <= '0;
		end else begin
			if (valid_s3) begin
				acc_q <= acc_q + ostm_pkg::ACC_W'(prod_s3);
			end
			if (valid_s2 && live_s2) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	assign done  = done_q;
	assign acc   = acc_q;
	assign count = count_q;

`ifndef SYNTHESIS
	a_hit_free_voice: assert property (@(posedge clk) disable iff (!arst_n)
		(start && hit.hit) |-> !active_q[hit.voice])
		else $error("hit placed on a sounding voice");
	a_done_drained: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (!sweep_q && !valid_s1 && !valid_s2 && !valid_s3))
		else $error("sum finished while voices still in flight");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= ostm_pkg::VOICE_COUNT)
		else $error("voice count above voice total");
`endif

endmodule

FILE: rtl/core/ostm_scaler.sv
// Scaler: applies density gain, output gain and full-scale factor to the voice sum
// on one shared multiplier, then saturates to 16 bits. Depends on ostm_pkg.
module ostm_scaler (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [ostm_pkg::ACC_W-1:0]   acc_in,
	input  logic [ostm_pkg::GAIN_W-1:0]         dgain,
	input  logic [ostm_pkg::GAIN_W-1:0]         ogain,
	input  logic                                take,
	output logic                                ready,
	output ostm_pkg::mix_res_t                  result
);

	ostm_pkg::scale_state_t state_q, state_d;
	logic [1:0]                        step_q;
	logic signed [ostm_pkg::M_W-1:0]   m_q;
	logic signed [ostm_pkg::P_W-1:0]   prod_q;

	logic                              load_en, mul_en, shift_en;
	logic [ostm_pkg::GAIN_W-1:0]       coef;
	logic signed [ostm_pkg::P_W-1:0]   biased, shifted;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ostm_pkg::SC_IDLE:  if (start) state_d = ostm_pkg::SC_MUL;
			ostm_pkg::SC_MUL:   state_d = ostm_pkg::SC_SHIFT;
			ostm_pkg::SC_SHIFT: begin
				if (step_q == ostm_pkg::STEP_FULL) begin
					state_d = ostm_pkg::SC_DONE;
				end else begin
					state_d = ostm_pkg::SC_MUL;
				end
			end
			ostm_pkg::SC_DONE:  if (take) state_d = ostm_pkg::SC_IDLE;
			default:            state_d = ostm_pkg::SC_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		load_en  = 1'b0;
		mul_en   = 1'b0;
		shift_en = 1'b0;
		ready    = 1'b0;
		unique case (state_q)
			ostm_pkg::SC_IDLE:  load_en  = start;
			ostm_pkg::SC_MUL:   mul_en   = 1'b1;
			ostm_pkg::SC_SHIFT: shift_en = 1'b1;
			ostm_pkg::SC_DONE:  ready    = 1'b1;
			default:            ready    = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ostm_pkg::SC_IDLE;
			step_q  <= ostm_pkg::STEP_DENSITY;
		end else begin
			state_q <= state_d;
			if (load_en) begin
				step_q <= ostm_pkg::STEP_DENSITY;
			end else if (shift_en) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// Pick the factor of this step
	always_comb begin
		unique case (step_q)
			ostm_pkg::STEP_DENSITY: coef = dgain;
			ostm_pkg::STEP_OUTPUT:  coef = ogain;
			default:                coef = ostm_pkg::FULL_SCALE;
		endcase
	end

	// Shift right, rounding toward zero
	always_comb begin
		if (step_q == ostm_pkg::STEP_FULL) begin
			biased  = prod_q + (prod_q[ostm_pkg::P_W-1] ? ostm_pkg::FINAL_MASK : '0);
			shifted = biased >>> ostm_pkg::FINAL_SHIFT;
		end else begin
			biased  = prod_q + (prod_q[ostm_pkg::P_W-1] ? ostm_pkg::GAIN_MASK : '0);
			shifted = biased >>> ostm_pkg::GAIN_SHIFT;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			m_q <= ostm_pkg::M_W'(acc_in);
		end else if (shift_en) begin
			m_q <= shifted[ostm_pkg::M_W-1:0];
		end
		if (mul_en) begin
			prod_q <= m_q * $signed({1'b0, coef});
		end
	end

	// Saturate to signed 16 bits
	always_comb begin
		if (m_q > ostm_pkg::SAT_MAX) begin
			result.sample  = ostm_pkg::SAMPLE_MAX;
			result.clipped = 1'b1;
		end else if (m_q < ostm_pkg::SAT_MIN) begin
			result.sample  = ostm_pkg::SAMPLE_MIN;
			result.clipped = 1'b1;
		end else begin
			result.sample  = m_q[ostm_pkg::SAMPLE_W-1:0];
			result.clipped = 1'b0;
		end
	end

endmodule
